[rtl/mbsp_pkg.sv]
`timescale 1ns / 1ps

package mbsp_pkg;

    // Byte classes
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] SYS_RESET    = 8'hFF;
    localparam logic [7:0] SYSEX_START  = 8'hF0;

    // Status nibbles with special byte counts
    localparam logic [3:0] NIBBLE_SYSTEM   = 4'hF;
    localparam logic [3:0] NIBBLE_PROGRAM  = 4'hC;
    localparam logic [3:0] NIBBLE_CHAN_PRS = 4'hD;

    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

    localparam logic [7:0] KEY_OFFSET = 8'd12;

    // Event kinds
    localparam logic [2:0] KIND_NOTE_OFF  = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON   = 3'd1;
    localparam logic [2:0] KIND_KEY_PRS   = 3'd2;
    localparam logic [2:0] KIND_CONTROL   = 3'd3;
    localparam logic [2:0] KIND_PROGRAM   = 3'd4;
    localparam logic [2:0] KIND_CHAN_PRS  = 3'd5;
    localparam logic [2:0] KIND_BEND      = 3'd6;
    localparam logic [2:0] KIND_RESET     = 3'd7;

    typedef struct packed {
        logic [3:0] status_nibble;
        logic       status_valid;
        logic [3:0] chan;
        logic [1:0] bytes_expected;
        logic [1:0] bytes_received;
        logic [6:0] data0;
        logic [6:0] data1;
    } parser_state_t;

    typedef struct packed {
        logic [2:0]        event_kind;
        logic [3:0]        channel;
        logic signed [7:0] key;
        logic [6:0]        velocity;
        logic [6:0]        ctrl_number;
        logic [6:0]        ctrl_value;
        logic [13:0]       bend_value;
    } midi_event_t;

endpackage

[rtl/mbsp_in_if.sv]
`timescale 1ns / 1ps

interface mbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/mbsp_out_if.sv]
`timescale 1ns / 1ps

interface mbsp_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [3:0]        channel;
    logic signed [7:0] key;
    logic [6:0]        velocity;
    logic [6:0]        ctrl_number;
    logic [6:0]        ctrl_value;
    logic [13:0]       bend_value;

    modport source (output valid, output event_kind, output channel, output key,
                    output velocity, output ctrl_number, output ctrl_value,
                    output bend_value, input ready);
    modport sink   (input valid, input event_kind, input channel, input key,
                    input velocity, input ctrl_number, input ctrl_value,
                    input bend_value, output ready);
endinterface

[rtl/midi_byte_stream_parser_core.sv]
`timescale 1ns / 1ps

// MIDI byte-stream parser with running status.
//
// byte_in   : one raw MIDI byte per request (valid/ready, in_byte).
// event_out : one decoded event per request: kind, channel, key, velocity,
//             controller number/value and 14-bit pitch bend.
// A status byte arms running status; every complete group of data bytes
// after it yields one event. Real-time bytes are ignored, except system
// reset, which yields a reset event and drops status. System-common bytes
// drop status; data without status and SysEx data are discarded.
// Timing: an event appears on event_out in the cycle after the byte that
// completes it is accepted. Throughput: one byte per cycle while event_out
// does not stall, set by the single state update between the parser registers and the event register.
// Reset: status, counts and the stored data bytes clear; no event pending.
// Stall: while event_out holds a request that is not taken, byte_in stalls;
// a byte is taken in the same cycle the pending event leaves.
module midi_byte_stream_parser_core (
    input logic        clk,
    input logic        rst_n,
    mbsp_in_if.sink    byte_in,
    mbsp_out_if.source event_out
);
    import mbsp_pkg::*;

    parser_state_t state_reg;
    parser_state_t state_next;
    midi_event_t   event_reg;
    midi_event_t   event_next;
    logic          emit;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          accept;

    // Take a byte whenever the event register is empty or emptying
    assign byte_in.ready = !out_valid_reg || event_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    mbsp_step u_step (
        .cur     (state_reg),
        .in_byte (byte_in.in_byte),
        .nxt     (state_next),
        .emit    (emit),
        .ev      (event_next)
    );

    // Hold the pending event until taken; accept implies it is leaving
    assign out_valid_next = accept ? emit : (out_valid_reg && !event_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load only when a new event is produced
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            event_reg <= event_next;
        end
    end

    assign event_out.valid       = out_valid_reg;
    assign event_out.event_kind  = event_reg.event_kind;
    assign event_out.channel     = event_reg.channel;
    assign event_out.key         = event_reg.key;
    assign event_out.velocity    = event_reg.velocity;
    assign event_out.ctrl_number = event_reg.ctrl_number;
    assign event_out.ctrl_value  = event_reg.ctrl_value;
    assign event_out.bend_value  = event_reg.bend_value;

    // A system reset byte always yields a reset event next cycle
    a_sys_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_in.in_byte == SYS_RESET
        |=> event_out.valid && event_out.event_kind == KIND_RESET
            && !state_reg.status_valid)
    else $error("system reset byte did not produce a reset event");

    // Ignored real-time bytes leave the parser state untouched
    a_realtime_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_in.in_byte >= REALTIME_MIN && byte_in.in_byte != SYS_RESET
        |=> state_reg == $past(state_reg))
    else $error("real-time byte disturbed running status");

    // The collected count never reaches a full two-byte group between bytes
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_received < COUNT_TWO)
    else $error("received byte count out of range");

    // A channel status byte arms status and restarts the count
    a_status_arms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_in.in_byte[7] && byte_in.in_byte < SYSEX_START
        |=> state_reg.status_valid && state_reg.bytes_received == COUNT_NONE
            && state_reg.bytes_expected != COUNT_NONE)
    else $error("status byte did not arm running status");

endmodule

[rtl/mbsp_step.sv]
`timescale 1ns / 1ps

module mbsp_step (
    input  mbsp_pkg::parser_state_t cur,
    input  logic [7:0]              in_byte,
    output mbsp_pkg::parser_state_t nxt,
    output logic                    emit,
    output mbsp_pkg::midi_event_t   ev
);
    import mbsp_pkg::*;

    logic [6:0] data0_new;
    logic [6:0] data1_new;
    logic [1:0] rcv_inc;
    logic [2:0] kind;

    always_comb
    begin
        data0_new = cur.data0;
        data1_new = cur.data1;
        if (cur.bytes_received == 2'd0)
        begin
            data0_new = in_byte[6:0];
        end
        else if (cur.bytes_received == 2'd1)
        begin
            data1_new = in_byte[6:0];
        end
        rcv_inc = cur.bytes_received + 2'd1;
        kind    = cur.status_nibble[2:0];
    end

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        ev   = '0;
        priority if (in_byte >= REALTIME_MIN)
        begin
            // only system reset acts; other real-time bytes pass untouched
            if (in_byte == SYS_RESET)
            begin
                nxt.status_valid = 1'b0;
                emit             = 1'b1;
                ev.event_kind    = KIND_RESET;
            end
        end
        else if (in_byte > SYSEX_START)
        begin
            nxt.status_valid = 1'b0;
        end
        else if (in_byte[7])
        begin
            nxt.chan           = in_byte[3:0];
            nxt.status_nibble  = in_byte[7:4];
            nxt.status_valid   = 1'b1;
            nxt.bytes_received = COUNT_NONE;
            priority if (in_byte[7:4] == NIBBLE_SYSTEM)
                nxt.bytes_expected = COUNT_NONE;
            else if (in_byte[7:4] == NIBBLE_PROGRAM || in_byte[7:4] == NIBBLE_CHAN_PRS)
                nxt.bytes_expected = COUNT_ONE;
            else
                nxt.bytes_expected = COUNT_TWO;
        end
        else if (cur.status_valid && cur.status_nibble[3]
                 && cur.status_nibble != NIBBLE_SYSTEM)
        begin
            nxt.data0 = data0_new;
            nxt.data1 = data1_new;
            if (rcv_inc < cur.bytes_expected)
            begin
                nxt.bytes_received = rcv_inc;
            end
            else
            begin
                nxt.bytes_received = COUNT_NONE;
                emit               = 1'b1;
                ev.event_kind      = kind;
                ev.channel         = cur.chan;
                unique case (kind)
                    KIND_CONTROL:
                    begin
                        ev.ctrl_number = data0_new;
                        ev.ctrl_value  = data1_new;
                    end
                    KIND_BEND:
                    begin
                        ev.bend_value = {data1_new, data0_new};
                    end
                    default:
                    begin
                        ev.key      = {1'b0, data0_new} - KEY_OFFSET;
                        ev.velocity = data1_new;
                    end
                endcase
            end
        end
        else
        begin
            // drop stray data and SysEx data; state holds
            nxt = cur;
        end
    end

endmodule
